[hdl/idac_pkg.sv]
// Shared types, constants and decode functions for the I2C DAC command decoder.
// Used by idac_ctrl, idac_dp, the top level and the checker; no dependencies.
package idac_pkg;

    // bus event codes
    localparam logic [2:0] MODE_START = 3'd0;
    localparam logic [2:0] MODE_ADDR  = 3'd1;
    localparam logic [2:0] MODE_DATA  = 3'd2;
    localparam logic [2:0] MODE_STOP  = 3'd3;

    // configuration registers
    localparam int REG_IDX_W = 1;
    localparam int CFG_W     = 23;
    localparam logic [REG_IDX_W-1:0] REG_VARIANT = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_VREF    = 1'b1;
    localparam logic [22:0] VREF_RESET = 23'd1500000;

    // resolution variants
    localparam logic [1:0] VAR_16 = 2'd0;
    localparam logic [1:0] VAR_14 = 2'd1;
    localparam logic [1:0] VAR_12 = 2'd2;

    localparam logic [15:0] FS_16 = 16'hFFFF;
    localparam logic [15:0] FS_14 = 16'h3FFF;
    localparam logic [15:0] FS_12 = 16'h0FFF;

    localparam logic [7:0] GLOBAL_ADDR = 8'h73;
    localparam logic [3:0] NIB_ALL     = 4'hF;

    // result kinds
    localparam logic [1:0] KIND_STRAP  = 2'd0;
    localparam logic [1:0] KIND_GLOBAL = 2'd1;
    localparam logic [1:0] KIND_CMD    = 2'd2;
    localparam logic [1:0] KIND_VOLT   = 2'd3;

    // decoded command codes
    localparam logic [2:0] CMD_WRITE   = 3'd0;
    localparam logic [2:0] CMD_UPDATE  = 3'd1;
    localparam logic [2:0] CMD_WR_UP   = 3'd2;
    localparam logic [2:0] CMD_PWR_DN  = 3'd3;
    localparam logic [2:0] CMD_NOP     = 3'd4;
    localparam logic [2:0] CMD_UNKNOWN = 3'd5;

    // decoded target codes
    localparam logic [1:0] TGT_A       = 2'd0;
    localparam logic [1:0] TGT_B       = 2'd1;
    localparam logic [1:0] TGT_ALL     = 2'd2;
    localparam logic [1:0] TGT_UNKNOWN = 2'd3;

    typedef enum logic [1:0] {
        OSEL_ADDR = 2'd0,
        OSEL_CMD  = 2'd1,
        OSEL_VOLT = 2'd2
    } out_sel_t;

    typedef struct packed {
        logic     take;
        logic     hold;
        logic     set_nibble;
        logic     clear_pending;
        logic     mul;
        logic     div_step;
        logic     load_out;
        out_sel_t out_sel;
        logic     second;
    } dp_cmd_t;

    typedef struct packed {
        logic pending;
        logic div_done;
        logic all_chan;
        logic out_free;
    } dp_status_t;

    typedef struct packed {
        logic [1:0] high;
        logic [1:0] mid;
        logic [1:0] low;
    } strap_t;

    typedef struct packed {
        logic [1:0]  kind;
        strap_t      strap;
        logic [2:0]  command_code;
        logic [1:0]  target_code;
        logic [3:0]  channel;
        logic [15:0] code;
        logic [22:0] voltage;
        logic        last;
    } result_t;

    function automatic logic [2:0] decode_command(input logic [3:0] nib);
        logic [2:0] c;
        unique case (nib)
            4'h0:    c = CMD_WRITE;
            4'h1:    c = CMD_UPDATE;
            4'h3:    c = CMD_WR_UP;
            4'h4:    c = CMD_PWR_DN;
            4'hF:    c = CMD_NOP;
            default: c = CMD_UNKNOWN;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] decode_target(input logic [3:0] nib);
        logic [1:0] t;
        unique case (nib)
            4'h0:    t = TGT_A;
            4'h1:    t = TGT_B;
            NIB_ALL: t = TGT_ALL;
            default: t = TGT_UNKNOWN;
        endcase
        return t;
    endfunction

    // Ternary pin straps from address bits 6:4 and 1:0, offset by four.
    // The top digit wraps mod 3.
    function automatic strap_t strap_decode(input logic [7:0] b);
        logic [4:0] n;
        logic [4:0] u;
        logic [4:0] r;
        strap_t     s;
        n = {b[6:4], b[1:0]};
        u = 5'd0;
        r = 5'd0;
        s = '0;
        if (n >= 5'd4) begin
            u = n - 5'd4;
            if (u >= 5'd27) begin
                s.high = 2'd0;
                r = u - 5'd27;
            end else if (u >= 5'd18) begin
                s.high = 2'd2;
                r = u - 5'd18;
            end else if (u >= 5'd9) begin
                s.high = 2'd1;
                r = u - 5'd9;
            end else begin
                s.high = 2'd0;
                r = u;
            end
            if (r >= 5'd6) begin
                s.mid = 2'd2;
                r = r - 5'd6;
            end else if (r >= 5'd3) begin
                s.mid = 2'd1;
                r = r - 5'd3;
            end else begin
                s.mid = 2'd0;
            end
            s.low = r[1:0];
        end
        return s;
    endfunction

endpackage

[hdl/idac_ctrl.sv]
// Controller for the I2C DAC command decoder: bus transaction phase and the
// sequencer that steps the datapath. Depends on idac_pkg.
module idac_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_mode,
    input  idac_pkg::dp_status_t status,
    output idac_pkg::dp_cmd_t   cmd
);
    import idac_pkg::*;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_SADDR = 4'b0010,
        PH_CMD   = 4'b0100,
        PH_DATA  = 4'b1000
    } phase_t;

    typedef enum logic [6:0] {
        ST_WAIT  = 7'b0000001,
        ST_ADDR  = 7'b0000010,
        ST_CMDR  = 7'b0000100,
        ST_MUL   = 7'b0001000,
        ST_DIV   = 7'b0010000,
        ST_VOLT  = 7'b0100000,
        ST_VOLT2 = 7'b1000000
    } seq_t;

    phase_t phase_reg, phase_next;
    seq_t   state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            state_reg <= ST_WAIT;
        end else begin
            phase_reg <= phase_next;
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_WAIT);

    always_comb begin
        cmd        = '0;
        cmd.out_sel = OSEL_ADDR;
        phase_next = phase_reg;
        state_next = state_reg;
        unique case (state_reg)
            ST_WAIT: begin
                if (s_valid) begin
                    cmd.take = 1'b1;
                    unique case (phase_reg)
                        PH_IDLE: begin
                            if (s_mode == MODE_START) begin
                                phase_next = PH_SADDR;
                            end
                        end
                        PH_SADDR: begin
                            if (s_mode == MODE_ADDR) begin
                                cmd.clear_pending = 1'b1;
                                phase_next = PH_CMD;
                                state_next = ST_ADDR;
                            end
                        end
                        PH_CMD: begin
                            if (s_mode == MODE_DATA) begin
                                cmd.clear_pending = 1'b1;
                                cmd.set_nibble = 1'b1;
                                phase_next = PH_DATA;
                                state_next = ST_CMDR;
                            end
                        end
                        PH_DATA: begin
                            if (s_mode == MODE_STOP) begin
                                phase_next = PH_IDLE;
                            end else if (s_mode == MODE_DATA) begin
                                if (!status.pending) begin
                                    cmd.hold = 1'b1;
                                end else begin
                                    cmd.clear_pending = 1'b1;
                                    state_next = ST_MUL;
                                end
                            end
                        end
                        default: phase_next = PH_IDLE;
                    endcase
                end
            end
            ST_ADDR: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.out_sel = OSEL_ADDR;
                    state_next = ST_WAIT;
                end
            end
            ST_CMDR: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.out_sel = OSEL_CMD;
                    state_next = ST_WAIT;
                end
            end
            ST_MUL: begin
                cmd.mul = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                // fold until the quotient is settled
                cmd.div_step = !status.div_done;
                if (status.div_done) begin
                    state_next = ST_VOLT;
                end
            end
            ST_VOLT: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.out_sel = OSEL_VOLT;
                    state_next = status.all_chan ? ST_VOLT2 : ST_WAIT;
                end
            end
            ST_VOLT2: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    cmd.out_sel = OSEL_VOLT;
                    cmd.second = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            default: state_next = ST_WAIT;
        endcase
    end

endmodule

[hdl/idac_dp.sv]
// Datapath for the I2C DAC command decoder: config registers, byte holding,
// code multiply, fold divider by 2^k-1 and the result register. Uses idac_pkg.
module idac_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [idac_pkg::REG_IDX_W-1:0]     cfg_idx,
    input  logic [idac_pkg::CFG_W-1:0]         cfg_wdata,
    input  logic [7:0]                         s_data_byte,
    input  idac_pkg::dp_cmd_t                  cmd,
    output idac_pkg::dp_status_t               status,
    input  logic                               m_ready,
    output logic                               m_valid,
    output idac_pkg::result_t                  result
);
    import idac_pkg::*;

    logic [1:0]  variant_reg;
    logic [22:0] vref_reg;
    logic        pending_reg;
    logic [7:0]  held_byte_reg;
    logic [3:0]  nibble_reg;
    logic [7:0]  in_byte_reg;
    logic [15:0] code_reg;
    logic [38:0] x_reg;
    logic [22:0] q_reg;
    logic        m_valid_reg;
    result_t     result_reg, result_next;

    logic [15:0] word;
    logic [15:0] code_next;
    logic [38:0] prod;
    logic [26:0] div_hi;
    logic [15:0] div_lo;
    logic [15:0] div_mask;
    logic [38:0] x_step;
    logic [22:0] q_step;
    logic [22:0] volt;
    logic        all_chan;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            variant_reg <= VAR_16;
            vref_reg    <= VREF_RESET;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                REG_VARIANT: variant_reg <= cfg_wdata[1:0];
                REG_VREF:    vref_reg    <= cfg_wdata[22:0];
                default:     ;
            endcase
        end
    end

    // transaction state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg   <= 1'b0;
            held_byte_reg <= 8'd0;
            nibble_reg    <= 4'd0;
        end else begin
            if (cmd.hold) begin
                pending_reg   <= 1'b1;
                held_byte_reg <= s_data_byte;
            end else if (cmd.clear_pending) begin
                pending_reg <= 1'b0;
            end
            if (cmd.set_nibble) begin
                nibble_reg <= s_data_byte[3:0];
            end
        end
    end

    always_comb begin
        word = {held_byte_reg, in_byte_reg};
        case (variant_reg)
            VAR_14:  code_next = {2'b00, word[15:2]};
            VAR_12:  code_next = {4'b0000, word[15:4]};
            default: code_next = word;
        endcase
    end

    assign prod = vref_reg * code_next;

    // x = hi*2^k + lo = hi*(2^k-1) + (hi+lo): move hi into the quotient, fold
    always_comb begin
        case (variant_reg)
            VAR_14: begin
                div_hi   = {2'b00, x_reg[38:14]};
                div_lo   = {2'b00, x_reg[13:0]};
                div_mask = FS_14;
            end
            VAR_12: begin
                div_hi   = x_reg[38:12];
                div_lo   = {4'b0000, x_reg[11:0]};
                div_mask = FS_12;
            end
            default: begin
                div_hi   = {4'b0000, x_reg[38:16]};
                div_lo   = x_reg[15:0];
                div_mask = FS_16;
            end
        endcase
        x_step = {12'd0, div_hi} + {23'd0, div_lo};
        q_step = q_reg + div_hi[22:0];
        volt   = q_reg + {22'd0, (div_lo == div_mask)};
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            in_byte_reg <= s_data_byte;
        end
        if (cmd.mul) begin
            code_reg <= code_next;
            x_reg    <= prod;
            q_reg    <= 23'd0;
        end else if (cmd.div_step) begin
            x_reg <= x_step;
            q_reg <= q_step;
        end
    end

    assign all_chan = (nibble_reg == NIB_ALL);

    always_comb begin
        result_next = '0;
        case (cmd.out_sel)
            OSEL_ADDR: begin
                result_next.last = 1'b1;
                if (in_byte_reg == GLOBAL_ADDR) begin
                    result_next.kind = KIND_GLOBAL;
                end else begin
                    result_next.kind  = KIND_STRAP;
                    result_next.strap = strap_decode(in_byte_reg);
                end
            end
            OSEL_CMD: begin
                result_next.kind         = KIND_CMD;
                result_next.command_code = decode_command(in_byte_reg[7:4]);
                result_next.target_code  = decode_target(nibble_reg);
                result_next.channel      = nibble_reg;
                result_next.last         = 1'b1;
            end
            OSEL_VOLT: begin
                result_next.kind    = KIND_VOLT;
                result_next.code    = code_reg;
                result_next.voltage = volt;
                if (cmd.second) begin
                    result_next.channel = 4'd1;
                end else if (all_chan) begin
                    result_next.channel = 4'd0;
                end else begin
                    result_next.channel = nibble_reg;
                end
                result_next.last = cmd.second || !all_chan;
            end
            default: result_next = '0;
        endcase
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            result_reg <= result_next;
        end
    end

    assign status.pending  = pending_reg;
    assign status.div_done = (div_hi == 27'd0);
    assign status.all_chan = all_chan;
    assign status.out_free = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign result  = result_reg;

endmodule

[hdl/i2c_dac_command_decoder_unit.sv]
// An address or command word is registered on input and then loaded into the output word
// register once the output is free; a voltage word passes the multiply state, the fold
// divider by 2^k-1 and the voltage load state after the second data byte, plus output stalls.
// Throughput: one input word per cycle when no result follows, else input is held off
// until the result words are loaded. Reset (aresetn low, synchronous) clears the phase,
// pending byte, held byte, channel nibble and output valid, and loads config defaults.
module i2c_dac_command_decoder_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [idac_pkg::REG_IDX_W-1:0] cfg_idx,
    input  logic [idac_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [2:0]                     s_mode,
    input  logic [7:0]                     s_data_byte,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_kind,
    output logic [1:0]                     m_strap_high,
    output logic [1:0]                     m_strap_mid,
    output logic [1:0]                     m_strap_low,
    output logic [2:0]                     m_command_code,
    output logic [1:0]                     m_target_code,
    output logic [3:0]                     m_channel,
    output logic [15:0]                    m_code,
    output logic [22:0]                    m_voltage_microvolts,
    output logic                           m_last
);
    import idac_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;
    result_t    result;

    idac_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_mode  (s_mode),
        .status  (status),
        .cmd     (cmd)
    );

    idac_dp u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_idx     (cfg_idx),
        .cfg_wdata   (cfg_wdata),
        .s_data_byte (s_data_byte),
        .cmd         (cmd),
        .status      (status),
        .m_ready     (m_ready),
        .m_valid     (m_valid),
        .result      (result)
    );

    assign m_kind               = result.kind;
    assign m_strap_high         = result.strap.high;
    assign m_strap_mid          = result.strap.mid;
    assign m_strap_low          = result.strap.low;
    assign m_command_code       = result.command_code;
    assign m_target_code        = result.target_code;
    assign m_channel            = result.channel;
    assign m_code               = result.code;
    assign m_voltage_microvolts = result.voltage;
    assign m_last               = result.last;

endmodule

[hdl/idac_checker.sv]
// Port-level checks for i2c_dac_command_decoder_unit, attached by bind.
// Depends on idac_pkg.
module idac_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_kind,
    input logic [1:0]  m_strap_high,
    input logic [1:0]  m_strap_mid,
    input logic [1:0]  m_strap_low,
    input logic [15:0] m_code,
    input logic [22:0] m_voltage_microvolts,
    input logic        m_last
);
    import idac_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_code)
            && $stable(m_voltage_microvolts) && $stable(m_last))
        else $error("result word changed while stalled");

    a_single_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind != KIND_VOLT) |-> m_last)
        else $error("address or command word without last");

    a_global_straps: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind == KIND_GLOBAL) |->
            (m_strap_high == 2'd0) && (m_strap_mid == 2'd0) && (m_strap_low == 2'd0))
        else $error("global address with straps set");

    a_no_volt_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind != KIND_VOLT) |-> (m_code == 16'd0)
            && (m_voltage_microvolts == 23'd0))
        else $error("voltage fields set on non-voltage word");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind i2c_dac_command_decoder_unit idac_checker u_checker (.*);
